// ===== rtl/peabu_pkg.sv =====
// types and constants for the execute stage (alu, address generation, branch resolution)
// no dependencies; imported by pipeline_execute_alu_branch_unit_top
package peabu_pkg;

    localparam int unsigned WORD_W = 32;
    localparam int unsigned OPC_W  = 5;

    typedef logic [WORD_W-1:0] word_t;
    typedef logic [OPC_W-1:0]  opc_t;

    // instruction opcodes; codes above OP_NOP behave as no-ops
    typedef enum logic [OPC_W-1:0] {
        OP_ADD    = 5'd0,
        OP_SUB    = 5'd1,
        OP_MUL    = 5'd2,
        OP_AND    = 5'd3,
        OP_OR     = 5'd4,
        OP_XOR    = 5'd5,
        OP_ADDL   = 5'd6,
        OP_SUBL   = 5'd7,
        OP_MOVC   = 5'd8,
        OP_LOAD   = 5'd9,
        OP_LOADP  = 5'd10,
        OP_STORE  = 5'd11,
        OP_STOREP = 5'd12,
        OP_CMP    = 5'd13,
        OP_CML    = 5'd14,
        OP_BZ     = 5'd15,
        OP_BNZ    = 5'd16,
        OP_BP     = 5'd17,
        OP_BNP    = 5'd18,
        OP_BN     = 5'd19,
        OP_BNN    = 5'd20,
        OP_JUMP   = 5'd21,
        OP_JALR   = 5'd22,
        OP_HALT   = 5'd23,
        OP_NOP    = 5'd24
    } op_t;

    // pointer and return address step
    localparam word_t PTR_STEP = word_t'(4);

    typedef struct packed {
        logic zero;
        logic positive;
        logic negative;
    } flags_t;

endpackage

// ===== rtl/pipeline_execute_alu_branch_unit_top.sv =====
// execute stage: alu, load/store address generation and branch resolution
// depends on peabu_pkg (opcodes, word and flag types)
//
// usage
// - input channel s_*: one decoded instruction per item (opcode, two source
//   values, immediate, pc), valid/ready handshake
// - result channel m_*: one result item per instruction: alu result, memory
//   address, post-increment pointer, redirect and target pc, and the three
//   condition flags as they stand after the instruction
// - path: an accepted item is held in the input register, then in the result
//   register, from which it is shown on m_*
// - throughput: one item per cycle while the receiver keeps m_ready high; the
//   only carried state is the three flag bits, updated in the same cycle the
//   item is executed, so the next item sees them at once
// - the 32x32 multiplier (low half kept) sits between the input register and
//   the result register and sets the cycle time
// - reset (aresetn low, synchronous) empties both registers and clears flags
// - when the receiver stalls the result is held; the input register still
//   takes one more item, after which s_ready falls until m_ready returns
module pipeline_execute_alu_branch_unit_top (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  peabu_pkg::opc_t      s_opcode,
    input  peabu_pkg::word_t     s_first_operand,
    input  peabu_pkg::word_t     s_second_operand,
    input  peabu_pkg::word_t     s_immediate,
    input  peabu_pkg::word_t     s_instr_pc,
    output logic                 m_valid,
    input  logic                 m_ready,
    output peabu_pkg::word_t     m_alu_result,
    output peabu_pkg::word_t     m_mem_address,
    output peabu_pkg::word_t     m_pointer_update,
    output logic                 m_redirect,
    output peabu_pkg::word_t     m_target_pc,
    output logic                 m_zero_out,
    output logic                 m_positive_out,
    output logic                 m_negative_out
);
    import peabu_pkg::*;

    // input register
    logic   in_valid_reg;
    opc_t   in_opcode_reg;
    word_t  in_first_reg;
    word_t  in_second_reg;
    word_t  in_imm_reg;
    word_t  in_pc_reg;

    // result register
    logic   out_valid_reg;
    word_t  out_result_reg;
    word_t  out_address_reg;
    word_t  out_pointer_reg;
    logic   out_redirect_reg;
    word_t  out_target_reg;
    flags_t out_flags_reg;

    // condition flags carried between items
    flags_t flags_reg;
    flags_t flags_next;

    word_t  res_next;
    word_t  addr_next;
    word_t  ptr_next;
    word_t  tgt_next;
    logic   redir_next;
    logic   set_all;
    logic   set_zero;
    logic   is_branch;
    logic   taken;

    logic   out_free;   // result register can take an item this cycle
    logic   advance;    // item moves from input to result register
    logic   s_accept;

    assign out_free = !out_valid_reg || m_ready;
    assign advance  = in_valid_reg && out_free;
    assign s_ready  = !in_valid_reg || out_free;
    assign s_accept = s_valid && s_ready;

    // execute logic
    always_comb begin
        res_next   = '0;
        addr_next  = '0;
        ptr_next   = '0;
        tgt_next   = '0;
        redir_next = 1'b0;
        set_all    = 1'b0;
        set_zero   = 1'b0;
        is_branch  = 1'b0;
        taken      = 1'b0;
        unique case (op_t'(in_opcode_reg)) inside
            OP_ADD: begin
                res_next = in_first_reg + in_second_reg;
                set_all  = 1'b1;
            end
            OP_SUB, OP_CMP: begin
                res_next = in_first_reg - in_second_reg;
                set_all  = 1'b1;
            end
            OP_MUL: begin
                res_next = in_first_reg * in_second_reg;
                set_all  = 1'b1;
            end
            OP_AND: begin
                res_next = in_first_reg & in_second_reg;
                set_all  = 1'b1;
            end
            OP_OR: begin
                res_next = in_first_reg | in_second_reg;
                set_all  = 1'b1;
            end
            OP_XOR: begin
                res_next = in_first_reg ^ in_second_reg;
                set_all  = 1'b1;
            end
            OP_ADDL: begin
                res_next = in_first_reg + in_imm_reg;
                set_all  = 1'b1;
            end
            OP_SUBL, OP_CML: begin
                res_next = in_first_reg - in_imm_reg;
                set_all  = 1'b1;
            end
            OP_MOVC: begin
                res_next = in_imm_reg;
                set_zero = 1'b1;
            end
            OP_LOAD: begin
                addr_next = in_first_reg + in_imm_reg;
            end
            OP_LOADP: begin
                addr_next = in_first_reg + in_imm_reg;
                ptr_next  = in_first_reg + PTR_STEP;
            end
            OP_STORE: begin
                addr_next = in_second_reg + in_imm_reg;
            end
            OP_STOREP: begin
                addr_next = in_second_reg + in_imm_reg;
                ptr_next  = in_second_reg + PTR_STEP;
            end
            OP_BZ: begin
                is_branch = 1'b1;
                taken     = flags_reg.zero;
            end
            OP_BNZ: begin
                is_branch = 1'b1;
                taken     = !flags_reg.zero;
            end
            OP_BP: begin
                is_branch = 1'b1;
                taken     = flags_reg.positive;
            end
            OP_BNP: begin
                is_branch = 1'b1;
                taken     = !flags_reg.positive;
            end
            OP_BN: begin
                is_branch = 1'b1;
                taken     = flags_reg.negative;
            end
            OP_BNN: begin
                is_branch = 1'b1;
                taken     = !flags_reg.negative;
            end
            OP_JUMP: begin
                redir_next = 1'b1;
                tgt_next   = in_first_reg + in_imm_reg;
            end
            OP_JALR: begin
                redir_next = 1'b1;
                tgt_next   = in_first_reg + in_imm_reg;
                res_next   = in_pc_reg + PTR_STEP;
            end
            default: begin
                // halt, nop and unused codes: nothing to do
            end
        endcase

        // taken conditional branch goes pc relative
        if (is_branch && taken) begin
            redir_next = 1'b1;
            tgt_next   = in_pc_reg + in_imm_reg;
        end

        // flags from the signed view of the result
        flags_next = flags_reg;
        if (set_all) begin
            flags_next.zero     = (res_next == '0);
            flags_next.negative = res_next[WORD_W-1];
            flags_next.positive = (res_next != '0) && !res_next[WORD_W-1];
        end else if (set_zero) begin
            flags_next.zero     = (res_next == '0);
        end
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            flags_reg     <= '0;
        end else begin
            if (s_accept) begin
                in_valid_reg <= 1'b1;
            end else if (advance) begin
                in_valid_reg <= 1'b0;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
                flags_reg     <= flags_next;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            in_opcode_reg <= s_opcode;
            in_first_reg  <= s_first_operand;
            in_second_reg <= s_second_operand;
            in_imm_reg    <= s_immediate;
            in_pc_reg     <= s_instr_pc;
        end
        if (advance) begin
            out_result_reg   <= res_next;
            out_address_reg  <= addr_next;
            out_pointer_reg  <= ptr_next;
            out_redirect_reg <= redir_next;
            out_target_reg   <= tgt_next;
            out_flags_reg    <= flags_next;
        end
    end

    assign m_valid          = out_valid_reg;
    assign m_alu_result     = out_result_reg;
    assign m_mem_address    = out_address_reg;
    assign m_pointer_update = out_pointer_reg;
    assign m_redirect       = out_redirect_reg;
    assign m_target_pc      = out_target_reg;
    assign m_zero_out       = out_flags_reg.zero;
    assign m_positive_out   = out_flags_reg.positive;
    assign m_negative_out   = out_flags_reg.negative;

    // flags only move when an item is executed
    assert property (@(posedge aclk) disable iff (!aresetn)
        !advance |=> $stable(flags_reg))
        else $error("flags changed without an item being executed");

    // input side only stalls when both registers hold an item
    assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> (in_valid_reg && out_valid_reg))
        else $error("input stalled with room in the pipeline");

    // no redirect means no target
    assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && !out_redirect_reg) |-> (out_target_reg == '0))
        else $error("target pc set without redirect");

    // shown flags match the carried flags when the pipe is drained
    assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && !in_valid_reg) |-> (out_flags_reg == flags_reg))
        else $error("result flags differ from carried flags");

endmodule
